// ===== src/pinio_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, register offsets and helper functions of the pinball I/O register file.
// Depends on nothing; every other file refers to it by scoped names.
package pinio_pkg;

	// Item kinds carried in the mode field.
	localparam logic [2:0] MODE_READ  = 3'd0;
	localparam logic [2:0] MODE_WRITE = 3'd1;
	localparam logic [2:0] MODE_TICK  = 3'd2;
	localparam logic [2:0] MODE_LEVEL = 3'd3;
	localparam logic [2:0] MODE_PRESS = 3'd4;

	// Register offsets from the block base.
	localparam logic [10:0] OFF_DMD_LOW    = 11'h3BE;
	localparam logic [10:0] OFF_DMD_HIGH   = 11'h3BC;
	localparam logic [10:0] OFF_LED        = 11'h3F2;
	localparam logic [10:0] OFF_ROM_BANK   = 11'h3FC;
	localparam logic [10:0] OFF_RAM_UNLOCK = 11'h3FD;
	localparam logic [10:0] OFF_RAM_LOCK   = 11'h3FE;
	localparam logic [10:0] OFF_SHIFT_HI   = 11'h3F4;
	localparam logic [10:0] OFF_SHIFT_LO   = 11'h3F5;
	localparam logic [10:0] OFF_SHIFT_BIT  = 11'h3F6;
	localparam logic [10:0] OFF_LAMP_ROW   = 11'h3E4;
	localparam logic [10:0] OFF_LAMP_STB   = 11'h3E5;
	localparam logic [10:0] OFF_SW_STROBE  = 11'h3EA;
	localparam logic [10:0] OFF_SW_STROBED = 11'h3E9;
	localparam logic [10:0] OFF_JUMPER     = 11'h3E7;
	localparam logic [10:0] OFF_SW_COL0    = 11'h3E8;
	localparam logic [10:0] OFF_SW_ALT_A   = 11'h3D4;
	localparam logic [10:0] OFF_SW_ALT_B   = 11'h3D5;
	localparam logic [10:0] OFF_SW_ALT_C   = 11'h3EF;

	localparam logic [7:0]  JUMPER_RESET   = 8'h55;
	localparam logic [3:0]  SW_COL_HIGH    = 4'd9;
	localparam logic [6:0]  SW_RESET_NUM   = 7'd19;
	localparam logic [7:0]  STB_DIRECT_LO  = 8'h16;
	localparam logic [7:0]  STB_DIRECT_HI  = 8'h1F;
	localparam logic [14:0] TICK_STEP      = 15'd100;
	localparam logic [13:0] RAM_BYTES      = 14'd8192;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	typedef struct packed {
		logic [2:0]  mode;
		logic [10:0] reg_offset;
		logic [7:0]  write_data;
		logic [6:0]  switch_number;
		logic        switch_level;
		logic [14:0] hold_time;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic [7:0]  rom_bank_now;
		logic [13:0] ram_writable_bytes;
		logic [7:0]  dmd_low_page_now;
		logic [7:0]  dmd_high_page_now;
		logic [7:0]  led_now;
		logic        lamp_update;
		logic [2:0]  lamp_column;
		logic [7:0]  lamp_row_data;
	} result_t;

	// Request into the switch matrix memory; rd_en and wr_en are only raised for a column in range.
	typedef struct packed {
		logic       rd_en;
		logic       wr_en;
		logic [3:0] col;
		logic [7:0] wdata;
	} swm_req_t;

	// Index of the highest set bit; zero input gives zero.
	function automatic logic [2:0] top_bit(input logic [7:0] v);
		logic [2:0] idx;
		idx = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (v[i]) begin
				idx = 3'(i);
			end
		end
		return idx;
	endfunction

	// Column contents right after reset: only the reset switch is closed.
	function automatic logic [7:0] sw_reset_col(input logic [3:0] col);
		logic [7:0] v;
		v = 8'd0;
		if (col == SW_RESET_NUM[6:3]) begin
			v = 8'(1) << SW_RESET_NUM[2:0];
		end
		return v;
	endfunction

	function automatic logic [13:0] writable_bytes(input logic [7:0] unlock,
			input logic [7:0] lock_size);
		logic [13:0] size;
		size = RAM_BYTES;
		if (unlock == 8'd0) begin
			case (lock_size)
				8'h0F:   size = RAM_BYTES - 14'd256;
				8'h07:   size = RAM_BYTES - 14'd1536;
				8'h03:   size = RAM_BYTES - 14'd1024;
				8'h01:   size = RAM_BYTES - 14'd2048;
				8'h00:   size = RAM_BYTES - 14'd4096;
				default: size = RAM_BYTES;
			endcase
		end
		return size;
	endfunction

endpackage

// ===== src/pinball_io_asic_registers.sv =====
`timescale 1ns / 1ps
// Top level of the pinball I/O register file: control, register bank and result register.
// Depends on pinio_pkg and pinio_swmem.
//
// Usage. Items arrive on the item channel (item_valid, item_stall, item) and each one
// produces exactly one result on the result channel (result_valid, result_stall, result).
// A transfer happens at a rising clock edge where valid is high and stall is low.
// Each item is a bus read, a bus write, a time tick, a switch level change or a timed
// switch press. The jumper value is written through cfg_valid, cfg_ready and cfg_data;
// cfg_ready is always high and writes belong to idle periods.
// Timing: an item is taken in the idle state and starts execution in the cycle after,
// when the switch matrix memory returns the column it needs; the result is registered
// when execution ends. No new item is taken until the last one is committed, because
// of the read-modify-write of the single-ported switch memory.
// The next item is taken while a finished result still waits in the result register.
// Reset: state, result valid and architectural registers clear, the jumper value returns
// to 0x55 and the switch matrix reads as all open except switch 19, through per-column
// valid bits with no clearing pass, so items are taken from the first cycle after reset.
// Receiver stall: a result waits in the output register; an item in execution holds
// until that register frees, and item_stall stays high meanwhile.
module pinball_io_asic_registers #(
	parameter int SWITCH_COLUMNS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  pinio_pkg::item_t   item,
	output logic               result_valid,
	input  logic               result_stall,
	output pinio_pkg::result_t result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [7:0]         cfg_data
);
	pinio_pkg::state_t state_q, state_d;

	logic accept, commit, out_free;

	// Architectural registers.
	logic [7:0]  jumper_q, led_q, rom_bank_q, ram_unlock_q, ram_lock_q;
	logic [15:0] shift_addr_q;
	logic [7:0]  shift_bit_q, lamp_strobe_q, sw_strobe_q, dmd_low_q, dmd_high_q;
	logic [6:0]  held_q;
	logic [14:0] hold_q;

	logic [7:0]  led_d, rom_bank_d, ram_unlock_d, ram_lock_d;
	logic [15:0] shift_addr_d;
	logic [7:0]  shift_bit_d, lamp_strobe_d, sw_strobe_d, dmd_low_d, dmd_high_d;
	logic [6:0]  held_d;
	logic [14:0] hold_d;

	// Item in execution and the column that was fetched for it.
	pinio_pkg::item_t item_q;
	logic [3:0]       col_q;
	logic             col_ok_q;

	logic [3:0] col_c, strobe_col;
	logic       col_need, col_ok_c;

	logic [7:0] sw_rdata, sw_wdata, sw_mask, col_rd;
	logic       sw_we;

	pinio_pkg::result_t result_d, result_q;
	logic               result_valid_q;
	pinio_pkg::swm_req_t swm_req;

	assign cfg_ready = 1'b1;
	assign out_free  = !result_valid_q || !result_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			pinio_pkg::ST_IDLE: begin
				if (item_valid) begin
					state_d = pinio_pkg::ST_EXEC;
				end
			end
			pinio_pkg::ST_EXEC: begin
				if (out_free) begin
					state_d = pinio_pkg::ST_IDLE;
				end
			end
			default: state_d = pinio_pkg::ST_IDLE;
		endcase
	end

	// Control outputs.
	always_comb begin
		item_stall = 1'b1;
		accept     = 1'b0;
		commit     = 1'b0;
		case (state_q)
			pinio_pkg::ST_IDLE: begin
				item_stall = 1'b0;
				accept     = item_valid;
			end
			pinio_pkg::ST_EXEC: begin
				commit = out_free;
			end
			default: begin
				item_stall = 1'b1;
			end
		endcase
	end

	// Column strobe decode: the direct range selects a column by value, otherwise the
	// highest set bit plus one, and a zero strobe selects column 0.
	always_comb begin
		if (sw_strobe_q inside {[pinio_pkg::STB_DIRECT_LO:pinio_pkg::STB_DIRECT_HI]}) begin
			strobe_col = 4'(sw_strobe_q - pinio_pkg::STB_DIRECT_LO + 8'd1);
		end else if (sw_strobe_q == 8'd0) begin
			strobe_col = 4'd0;
		end else begin
			strobe_col = {1'b0, pinio_pkg::top_bit(sw_strobe_q)} + 4'd1;
		end
	end

	// Which switch column the incoming item needs.
	always_comb begin
		col_c    = 4'd0;
		col_need = 1'b0;
		case (item.mode)
			pinio_pkg::MODE_READ: begin
				case (item.reg_offset)
					pinio_pkg::OFF_SW_STROBED: begin
						col_c    = strobe_col;
						col_need = 1'b1;
					end
					pinio_pkg::OFF_SW_COL0: begin
						col_c    = 4'd0;
						col_need = 1'b1;
					end
					pinio_pkg::OFF_SW_ALT_A, pinio_pkg::OFF_SW_ALT_B,
					pinio_pkg::OFF_SW_ALT_C: begin
						col_c    = pinio_pkg::SW_COL_HIGH;
						col_need = 1'b1;
					end
					default: col_need = 1'b0;
				endcase
			end
			pinio_pkg::MODE_TICK: begin
				col_c    = held_q[6:3];
				col_need = (hold_q != 15'd0);
			end
			pinio_pkg::MODE_LEVEL, pinio_pkg::MODE_PRESS: begin
				col_c    = item.switch_number[6:3];
				col_need = 1'b1;
			end
			default: col_need = 1'b0;
		endcase
		col_ok_c = col_need && ({1'b0, col_c} < 5'(SWITCH_COLUMNS));
	end

	// Reads and writes of the memory never share a cycle: reads go out at accept in
	// idle, write-back at commit in execute, so a read always sees the last write.
	always_comb begin
		swm_req.rd_en = accept && col_ok_c;
		swm_req.wr_en = commit && sw_we;
		swm_req.col   = commit ? col_q : col_c;
		swm_req.wdata = sw_wdata;
	end

	pinio_swmem #(
		.SWITCH_COLUMNS(SWITCH_COLUMNS)
	) u_swmem (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (swm_req),
		.rdata  (sw_rdata)
	);

	assign col_rd = col_ok_q ? sw_rdata : 8'd0;

	// Execute: decode the held item against the registers and the fetched column.
	always_comb begin
		led_d         = led_q;
		rom_bank_d    = rom_bank_q;
		ram_unlock_d  = ram_unlock_q;
		ram_lock_d    = ram_lock_q;
		shift_addr_d  = shift_addr_q;
		shift_bit_d   = shift_bit_q;
		lamp_strobe_d = lamp_strobe_q;
		sw_strobe_d   = sw_strobe_q;
		dmd_low_d     = dmd_low_q;
		dmd_high_d    = dmd_high_q;
		held_d        = held_q;
		hold_d        = hold_q;
		sw_we         = 1'b0;
		sw_wdata      = sw_rdata;
		sw_mask       = 8'(1) << item_q.switch_number[2:0];
		result_d      = '0;

		case (item_q.mode)
			pinio_pkg::MODE_READ: begin
				case (item_q.reg_offset)
					pinio_pkg::OFF_LED:        result_d.read_data = led_q;
					pinio_pkg::OFF_ROM_BANK:   result_d.read_data = rom_bank_q;
					pinio_pkg::OFF_SHIFT_HI:   result_d.read_data = shift_addr_q[15:8];
					pinio_pkg::OFF_SHIFT_LO:
						result_d.read_data = shift_addr_q[7:0] + {3'd0, shift_bit_q[7:3]};
					pinio_pkg::OFF_SHIFT_BIT:
						result_d.read_data = 8'(1) << shift_bit_q[2:0];
					pinio_pkg::OFF_JUMPER:     result_d.read_data = jumper_q;
					pinio_pkg::OFF_SW_STROBED, pinio_pkg::OFF_SW_COL0,
					pinio_pkg::OFF_SW_ALT_A, pinio_pkg::OFF_SW_ALT_B,
					pinio_pkg::OFF_SW_ALT_C:   result_d.read_data = col_rd;
					default:                   result_d.read_data = 8'd0;
				endcase
			end
			pinio_pkg::MODE_WRITE: begin
				case (item_q.reg_offset)
					pinio_pkg::OFF_DMD_LOW:    dmd_low_d    = item_q.write_data;
					pinio_pkg::OFF_DMD_HIGH:   dmd_high_d   = item_q.write_data;
					pinio_pkg::OFF_LED:        led_d        = item_q.write_data;
					pinio_pkg::OFF_ROM_BANK:   rom_bank_d   = item_q.write_data;
					pinio_pkg::OFF_RAM_UNLOCK: ram_unlock_d = item_q.write_data;
					pinio_pkg::OFF_RAM_LOCK:   ram_lock_d   = item_q.write_data;
					pinio_pkg::OFF_SHIFT_HI:   shift_addr_d[15:8] = item_q.write_data;
					pinio_pkg::OFF_SHIFT_LO:   shift_addr_d[7:0]  = item_q.write_data;
					pinio_pkg::OFF_SHIFT_BIT:  shift_bit_d  = item_q.write_data;
					pinio_pkg::OFF_LAMP_ROW: begin
						// A zero strobe selects no column, so the write is dropped.
						if (lamp_strobe_q != 8'd0) begin
							result_d.lamp_update   = 1'b1;
							result_d.lamp_column   = pinio_pkg::top_bit(lamp_strobe_q);
							result_d.lamp_row_data = item_q.write_data;
						end
					end
					pinio_pkg::OFF_LAMP_STB:   lamp_strobe_d = item_q.write_data;
					pinio_pkg::OFF_SW_STROBE:  sw_strobe_d   = item_q.write_data;
					default:                   led_d         = led_q;
				endcase
			end
			pinio_pkg::MODE_TICK: begin
				if (hold_q != 15'd0) begin
					if (hold_q <= pinio_pkg::TICK_STEP) begin
						hold_d   = 15'd0;
						sw_we    = col_ok_q;
						sw_wdata = sw_rdata & ~(8'(1) << held_q[2:0]);
					end else begin
						hold_d = hold_q - pinio_pkg::TICK_STEP;
					end
				end
			end
			pinio_pkg::MODE_LEVEL: begin
				sw_we    = col_ok_q;
				sw_wdata = item_q.switch_level ? (sw_rdata | sw_mask) : (sw_rdata & ~sw_mask);
			end
			pinio_pkg::MODE_PRESS: begin
				sw_we    = col_ok_q;
				sw_wdata = sw_rdata | sw_mask;
				held_d   = item_q.switch_number;
				hold_d   = item_q.hold_time;
			end
			default: sw_we = 1'b0;
		endcase

		result_d.rom_bank_now       = rom_bank_d;
		result_d.ram_writable_bytes = pinio_pkg::writable_bytes(ram_unlock_d, ram_lock_d);
		result_d.dmd_low_page_now   = dmd_low_d;
		result_d.dmd_high_page_now  = dmd_high_d;
		result_d.led_now            = led_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= pinio_pkg::ST_IDLE;
			result_valid_q <= 1'b0;
			jumper_q       <= pinio_pkg::JUMPER_RESET;
			led_q          <= 8'd0;
			rom_bank_q     <= 8'd0;
			ram_unlock_q   <= 8'd0;
			ram_lock_q     <= 8'd0;
			shift_addr_q   <= 16'd0;
			shift_bit_q    <= 8'd0;
			lamp_strobe_q  <= 8'd0;
			sw_strobe_q    <= 8'd0;
			dmd_low_q      <= 8'd0;
			dmd_high_q     <= 8'd0;
			held_q         <= 7'd0;
			hold_q         <= 15'd0;
		end else begin
			state_q <= state_d;
			if (cfg_valid && cfg_ready) begin
				jumper_q <= cfg_data;
			end
			if (commit) begin
				result_valid_q <= 1'b1;
				led_q          <= led_d;
				rom_bank_q     <= rom_bank_d;
				ram_unlock_q   <= ram_unlock_d;
				ram_lock_q     <= ram_lock_d;
				shift_addr_q   <= shift_addr_d;
				shift_bit_q    <= shift_bit_d;
				lamp_strobe_q  <= lamp_strobe_d;
				sw_strobe_q    <= sw_strobe_d;
				dmd_low_q      <= dmd_low_d;
				dmd_high_q     <= dmd_high_d;
				held_q         <= held_d;
				hold_q         <= hold_d;
			end else if (!result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= item;
			col_q    <= col_c;
			col_ok_q <= col_ok_c;
		end
		if (commit) begin
			result_q <= result_d;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

	a_mem_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		swm_req.wr_en |-> !swm_req.rd_en)
		else $error("switch memory read and write in the same cycle");

	a_accept_to_exec: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == pinio_pkg::ST_EXEC))
		else $error("accepted item did not enter execution");

	a_result_from_exec: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid_q) |-> $past(state_q == pinio_pkg::ST_EXEC))
		else $error("result appeared without an executed item");

	a_lamp_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid_q && !result_q.lamp_update) |->
		(result_q.lamp_column == 3'd0 && result_q.lamp_row_data == 8'd0))
		else $error("lamp fields set without a lamp update");

endmodule

// ===== src/pinio_swmem.sv =====
`timescale 1ns / 1ps
// Switch matrix memory: one byte per column, registered read, per-column valid bits.
// Depends on pinio_pkg for the request struct and the reset column contents.
module pinio_swmem #(
	parameter int SWITCH_COLUMNS = 10
) (
	input  logic               clk,
	input  logic               arst_n,
	input  pinio_pkg::swm_req_t req,
	output logic [7:0]         rdata
);
	localparam int AW = (SWITCH_COLUMNS > 1) ? $clog2(SWITCH_COLUMNS) : 1;

	logic [7:0]                mem [SWITCH_COLUMNS];
	logic [SWITCH_COLUMNS-1:0] valid_q;
	logic [7:0]                rd_q;
	logic                      rd_valid_q;
	logic [3:0]                rd_col_q;
	logic [AW-1:0]             addr;

	assign addr = req.col[AW-1:0];

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[addr] <= req.wdata;
		end
		if (req.rd_en) begin
			rd_q     <= mem[addr];
			rd_col_q <= req.col;
		end
	end

	// A column that was never written reads as its reset contents.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (req.wr_en) begin
				valid_q[addr] <= 1'b1;
			end
			if (req.rd_en) begin
				rd_valid_q <= valid_q[addr];
			end
		end
	end

	assign rdata = rd_valid_q ? rd_q : pinio_pkg::sw_reset_col(rd_col_q);

endmodule
